>>> hw/rtl/utf8sd_pkg.sv
// shared types, constants and helpers for the utf-8 stream decoder
package utf8sd_pkg;

  localparam int unsigned CP_W    = 21;
  localparam int unsigned LEN_W   = 3;
  localparam int unsigned LEFT_W  = 2;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_ENC_ERR   = 2'd1,
    ST_TOO_FEW   = 2'd2
  } status_t;

  // sequence lengths
  localparam logic [LEN_W-1:0] LEN_NONE = 3'd0;
  localparam logic [LEN_W-1:0] LEN_ONE  = 3'd1;
  localparam logic [LEN_W-1:0] LEN_TWO  = 3'd2;
  localparam logic [LEN_W-1:0] LEN_THR  = 3'd3;
  localparam logic [LEN_W-1:0] LEN_FOUR = 3'd4;

  // shortest encoding length for a code point
  function automatic logic [LEN_W-1:0] needed_length(input logic [CP_W-1:0] cp);
    logic [LEN_W-1:0] n;
    if (cp < 21'h80) n = LEN_ONE;
    else if (cp < 21'h800) n = LEN_TWO;
    else if (cp < 21'h10000) n = LEN_THR;
    else n = LEN_FOUR;
    return n;
  endfunction

endpackage

>>> hw/rtl/utf8_stream_decoder_top.sv
// utf-8 stream decoder top level: byte input register, decode logic, result register
//
// Decodes a UTF-8 byte stream at one byte per clock while no stalled result
// blocks the decode stage. Each accepted byte lands in an input register; the
// decode logic then combines it with the open-sequence state and, if the byte
// ends a sequence or hits an error, writes one result into the output register.
// Bytes that only extend a sequence produce no transaction. The output register
// lets the next byte be taken while a result waits; when that result stalls and
// another byte also needs to report, in_ready drops until out_ready frees the
// output register.
// Overlong forms, stray continuation bytes and leads 0xF8 and above are
// encoding errors; end_of_data inside an open sequence gives too-few-bytes.
module utf8_stream_decoder_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [7:0]                       in_byte_in,
  input  logic                             in_end_of_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [utf8sd_pkg::CP_W-1:0]      out_code_point,
  output logic [1:0]                       out_status,
  output logic [utf8sd_pkg::LEN_W-1:0]     out_length
);

  // input register
  logic                              in_vld_r;
  logic [7:0]                        in_byte_r;
  logic                              in_eod_r;

  // open sequence state
  logic [utf8sd_pkg::LEFT_W-1:0]     left_r, left_nxt;
  logic [utf8sd_pkg::LEN_W-1:0]      seq_len_r, seq_len_nxt;
  logic [utf8sd_pkg::CP_W-1:0]       acc_r, acc_nxt;
  logic                              bad_r, bad_nxt;

  // result register
  logic                              out_vld_r;
  logic [utf8sd_pkg::CP_W-1:0]       cp_r;
  utf8sd_pkg::status_t               st_r;
  logic [utf8sd_pkg::LEN_W-1:0]      len_r;

  // decode outputs
  logic                              res_vld;
  logic [utf8sd_pkg::CP_W-1:0]       res_cp;
  utf8sd_pkg::status_t               res_st;
  logic [utf8sd_pkg::LEN_W-1:0]      res_len;
  logic                              fire;

  logic [utf8sd_pkg::CP_W-1:0]       acc_shift;
  logic [utf8sd_pkg::LEFT_W-1:0]     left_dec;

  assign acc_shift = {acc_r[utf8sd_pkg::CP_W-7:0], in_byte_r[5:0]};
  assign left_dec  = left_r - 2'd1;

  // decode one byte against the open sequence
  always_comb begin
    res_vld     = 1'b0;
    res_cp      = '0;
    res_st      = utf8sd_pkg::ST_OK;
    res_len     = utf8sd_pkg::LEN_NONE;
    left_nxt    = left_r;
    seq_len_nxt = seq_len_r;
    acc_nxt     = acc_r;
    bad_nxt     = bad_r;
    if (left_r == '0) begin
      if (in_byte_r[7] == 1'b0) begin
        res_vld = 1'b1;
        res_cp  = {13'd0, in_byte_r};
        res_len = utf8sd_pkg::LEN_ONE;
      end else if (in_byte_r[7:5] == 3'b110 || in_byte_r[7:4] == 4'b1110 ||
                   in_byte_r[7:3] == 5'b11110) begin
        if (in_eod_r) begin
          res_vld = 1'b1;
          res_st  = utf8sd_pkg::ST_TOO_FEW;
        end else begin
          bad_nxt = 1'b0;
          if (in_byte_r[7:5] == 3'b110) begin
            seq_len_nxt = utf8sd_pkg::LEN_TWO;
            left_nxt    = 2'd1;
            acc_nxt     = {16'd0, in_byte_r[4:0]};
          end else if (in_byte_r[7:4] == 4'b1110) begin
            seq_len_nxt = utf8sd_pkg::LEN_THR;
            left_nxt    = 2'd2;
            acc_nxt     = {17'd0, in_byte_r[3:0]};
          end else begin
            seq_len_nxt = utf8sd_pkg::LEN_FOUR;
            left_nxt    = 2'd3;
            acc_nxt     = {18'd0, in_byte_r[2:0]};
          end
        end
      end else begin
        res_vld = 1'b1;
        res_st  = utf8sd_pkg::ST_ENC_ERR;
      end
    end else begin
      acc_nxt  = acc_shift;
      left_nxt = left_dec;
      bad_nxt  = bad_r | (in_byte_r[7:6] != 2'b10);
      if (left_dec != '0) begin
        if (in_eod_r) begin
          res_vld = 1'b1;
          res_st  = utf8sd_pkg::ST_TOO_FEW;
        end
      end else begin
        res_vld = 1'b1;
        if (bad_nxt || utf8sd_pkg::needed_length(acc_shift) != seq_len_r) begin
          res_st = utf8sd_pkg::ST_ENC_ERR;
        end else begin
          res_cp  = acc_shift;
          res_len = seq_len_r;
        end
      end
    end
    // any result closes the sequence
    if (res_vld) begin
      left_nxt    = '0;
      seq_len_nxt = utf8sd_pkg::LEN_NONE;
      acc_nxt     = '0;
      bad_nxt     = 1'b0;
    end
  end

  // decode stage advances unless its result would overwrite a stalled one
  assign fire     = in_vld_r && (!res_vld || !out_vld_r || out_ready);
  assign in_ready = !in_vld_r || fire;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
    if (in_valid && in_ready) begin
      in_byte_r <= in_byte_in;
      in_eod_r  <= in_end_of_data;
    end
  end

  // sequence state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r    <= '0;
      seq_len_r <= utf8sd_pkg::LEN_NONE;
      acc_r     <= '0;
      bad_r     <= 1'b0;
    end else if (fire) begin
      left_r    <= left_nxt;
      seq_len_r <= seq_len_nxt;
      acc_r     <= acc_nxt;
      bad_r     <= bad_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (fire && res_vld) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
    if (fire && res_vld) begin
      cp_r  <= res_cp;
      st_r  <= res_st;
      len_r <= res_len;
    end
  end

  assign out_valid      = out_vld_r;
  assign out_code_point = cp_r;
  assign out_status     = st_r;
  assign out_length     = len_r;

  // an error transaction carries no code point and no length
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && st_r != utf8sd_pkg::ST_OK) |-> (cp_r == '0 && len_r == utf8sd_pkg::LEN_NONE))
    else $error("error result with nonzero payload");

  // a good transaction has a real length
  a_ok_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && st_r == utf8sd_pkg::ST_OK) |->
      (len_r != utf8sd_pkg::LEN_NONE && len_r <= utf8sd_pkg::LEN_FOUR))
    else $error("ok result with bad length");

  // an open sequence always has more bytes in total than remain
  a_seq_len: assert property (@(posedge clk) disable iff (!rst_n)
    (left_r != '0) |-> ({1'b0, left_r} < seq_len_r))
    else $error("sequence length below remaining count");

  // end of data always leaves the decoder waiting for a lead byte
  a_eod_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && in_eod_r) |=> (left_r == '0))
    else $error("sequence left open after end of data");

  // a stalled result is never overwritten
  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_ready) |=> (out_vld_r && $stable(cp_r) && $stable(st_r)))
    else $error("stalled result changed");

endmodule
